FILE: rtl/rmst_pkg.sv
// Shared types, constants and helpers for the range-minimum segment tree.
`timescale 1ns / 1ps
package rmst_pkg;

   localparam int ENTRIES    = 256;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int NODE_BITS  = IDX_BITS + 1;
   localparam int NODES      = 2 * ENTRIES;
   localparam int PTR_BITS   = NODE_BITS + 1;
   localparam int COUNT_BITS = 9;

   localparam logic signed [VALUE_BITS-1:0] INT_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(ENTRIES);
   localparam logic [NODE_BITS-1:0] ROOT_NODE = NODE_BITS'(1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_UP,
      ST_QUERY
   } state_type;

   typedef struct packed {
      logic                         operation;
      logic [IDX_BITS-1:0]          index;
      logic signed [VALUE_BITS-1:0] value;
      logic [IDX_BITS-1:0]          range_low;
      logic [IDX_BITS-1:0]          range_high;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] minimum;
      logic [1:0]                   status;
   } rsp_type;

   typedef struct packed {
      logic                         wr_en;
      logic [NODE_BITS-1:0]         wr_addr;
      logic signed [VALUE_BITS-1:0] wr_data;
      logic [NODE_BITS-1:0]         rd_addr_a;
      logic [NODE_BITS-1:0]         rd_addr_b;
   } mem_req_type;

   function automatic logic signed [VALUE_BITS-1:0] min_value(
      input logic signed [VALUE_BITS-1:0] a,
      input logic signed [VALUE_BITS-1:0] b
   );
      return (a < b) ? a : b;
   endfunction

endpackage

FILE: rtl/rmst_node_mem.sv
// Node store of the segment tree: one write port, two registered read ports.
`timescale 1ns / 1ps
module rmst_node_mem (
   input  logic                                  clock,
   input  rmst_pkg::mem_req_type                 mem_req,
   output logic signed [rmst_pkg::VALUE_BITS-1:0] rd_data_a,
   output logic signed [rmst_pkg::VALUE_BITS-1:0] rd_data_b
);
   import rmst_pkg::*;

   logic signed [VALUE_BITS-1:0] nodes_ff [NODES];
   logic signed [VALUE_BITS-1:0] rd_a_ff;
   logic signed [VALUE_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         nodes_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_a_ff <= nodes_ff[mem_req.rd_addr_a];
      rd_b_ff <= nodes_ff[mem_req.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/range_minimum_segment_tree.sv
// Range-minimum segment tree over 256 signed 32-bit positions, nodes in one 2R1W memory.
// A write stores the leaf, then walks the read-modify-write path through each of the 8 levels
// up to the root. A query has a setup step, a bottom-up walk of 1 to 9 steps with up to two
// node reads each, and a final fold. Rejected writes and empty queries answer in the next
// cycle. One item at a time; busy drops as rsp_valid rises, the receiver cannot stall.
// Reset starts a clearing pass that writes INT_MAX to all 512 nodes.
`timescale 1ns / 1ps
module range_minimum_segment_tree (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  rmst_pkg::req_type                     req,
   output logic                                  rsp_valid,
   output rmst_pkg::rsp_type                     rsp,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rmst_pkg::COUNT_BITS-1:0]       csr_data
);
   import rmst_pkg::*;

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]        count_ff;
   logic [NODE_BITS-1:0]         clr_ff, clr_in;
   logic [NODE_BITS-1:0]         node_ff, node_in;
   logic signed [VALUE_BITS-1:0] cur_ff, cur_in;
   logic [PTR_BITS-1:0]          a_ff, a_in;
   logic [PTR_BITS-1:0]          b_ff, b_in;
   logic signed [VALUE_BITS-1:0] best_ff, best_in;
   logic                         pend_a_ff, pend_a_in;
   logic                         pend_b_ff, pend_b_in;
   rsp_type                      rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   mem_req_type                  mem_req;
   logic signed [VALUE_BITS-1:0] rd_data_a;
   logic signed [VALUE_BITS-1:0] rd_data_b;

   logic                         accept;
   logic [COUNT_BITS-1:0]        eff_count;
   logic [COUNT_BITS-1:0]        hi_ext;
   logic [COUNT_BITS-1:0]        hi_clip;
   logic                         wr_ok;
   logic                         q_empty;
   logic [NODE_BITS-1:0]         leaf;
   logic [NODE_BITS-1:0]         parent;
   logic signed [VALUE_BITS-1:0] up_min;
   logic signed [VALUE_BITS-1:0] acc;
   logic                         q_more;
   logic [PTR_BITS-1:0]          a_step;
   logic [PTR_BITS-1:0]          b_step;

   rmst_node_mem u_node_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Counts above the tree size saturate; the upper bound of a query is clipped to count minus one.
   assign eff_count = (count_ff > COUNT_RESET) ? COUNT_RESET : count_ff;
   assign hi_ext    = COUNT_BITS'(req.range_high);
   assign hi_clip   = (hi_ext >= eff_count) ? (eff_count - COUNT_BITS'(1)) : hi_ext;
   assign wr_ok     = COUNT_BITS'(req.index) < eff_count;
   assign q_empty   = (eff_count == '0) || (COUNT_BITS'(req.range_low) > hi_clip);
   assign leaf      = {1'b1, req.index};

   assign parent = {1'b0, node_ff[NODE_BITS-1:1]};
   assign up_min = min_value(cur_ff, rd_data_a);
   assign q_more = a_ff < b_ff;
   assign a_step = a_ff + PTR_BITS'(a_ff[0]);
   assign b_step = b_ff - PTR_BITS'(b_ff[0]);

   always_comb begin
      acc = best_ff;
      if (pend_a_ff) begin
         acc = min_value(acc, rd_data_a);
      end
      if (pend_b_ff) begin
         acc = min_value(acc, rd_data_b);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req.operation == OP_QUERY) begin
                  if (!q_empty) begin
                     state_in = ST_QUERY;
                  end
               end else if (wr_ok) begin
                  state_in = ST_WR_UP;
               end
            end
         end
         ST_WR_UP: begin
            if (parent == ROOT_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (!q_more) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      mem_req      = '0;
      clr_in       = clr_ff;
      node_in      = node_ff;
      cur_in       = cur_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      best_in      = best_ff;
      pend_a_in    = 1'b0;
      pend_b_in    = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            mem_req.wr_data = INT_MAX;
            clr_in          = clr_ff + NODE_BITS'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               if (req.operation == OP_QUERY) begin
                  if (q_empty) begin
                     rsp_in.minimum = INT_MAX;
                     rsp_in.status  = STATUS_EMPTY;
                     rsp_valid_in   = 1'b1;
                  end else begin
                     a_in    = PTR_BITS'({1'b1, req.range_low});
                     b_in    = PTR_BITS'({1'b1, hi_clip[IDX_BITS-1:0]}) + PTR_BITS'(1);
                     best_in = INT_MAX;
                  end
               end else if (wr_ok) begin
                  // Write the leaf and fetch its sibling for the first parent update.
                  mem_req.wr_en     = 1'b1;
                  mem_req.wr_addr   = leaf;
                  mem_req.wr_data   = req.value;
                  mem_req.rd_addr_a = leaf ^ NODE_BITS'(1);
                  node_in           = leaf;
                  cur_in            = req.value;
               end else begin
                  rsp_in.minimum = '0;
                  rsp_in.status  = STATUS_RANGE;
                  rsp_valid_in   = 1'b1;
               end
            end
         end
         ST_WR_UP: begin
            // The sibling read is never to the node written in the same cycle.
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = parent;
            mem_req.wr_data = up_min;
            node_in         = parent;
            cur_in          = up_min;
            if (parent == ROOT_NODE) begin
               rsp_in.minimum = '0;
               rsp_in.status  = STATUS_OK;
               rsp_valid_in   = 1'b1;
            end else begin
               mem_req.rd_addr_a = parent ^ NODE_BITS'(1);
            end
         end
         ST_QUERY: begin
            // Reads issued in one cycle are folded into the minimum in the next.
            best_in = acc;
            if (q_more) begin
               mem_req.rd_addr_a = a_ff[NODE_BITS-1:0];
               mem_req.rd_addr_b = b_step[NODE_BITS-1:0];
               pend_a_in         = a_ff[0];
               pend_b_in         = b_ff[0];
               a_in              = a_step >> 1;
               b_in              = b_step >> 1;
            end else begin
               rsp_in.minimum = acc;
               rsp_in.status  = STATUS_OK;
               rsp_valid_in   = 1'b1;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= COUNT_RESET;
         pend_a_ff    <= 1'b0;
         pend_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_a_ff    <= pend_a_in;
         pend_b_ff    <= pend_b_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      cur_ff  <= cur_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid)
      else $error("result transfer during the clearing pass");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy || rsp_valid)
      else $error("accepted item neither in progress nor answered");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == STATUS_RANGE |-> rsp.minimum == '0)
      else $error("rejected write carries a nonzero minimum");

   a_walk_above_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR_UP |-> node_ff > ROOT_NODE)
      else $error("write walk passed the root");

endmodule
